[hw/rtl/rsst_pkg.sv]
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types and codes of the range-sum segment tree core.
// ----------------------------------------------------------------------------
package rsst_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // count in use after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // operation codes
    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // request item
    typedef struct packed {
        logic                      func;
        logic [INDEX_W-1:0]        position;
        logic signed [DATA_W-1:0]  new_value;
        logic [INDEX_W-1:0]        range_left;
        logic [INDEX_W-1:0]        range_right;
    } req_t;

    // response item
    typedef struct packed {
        logic signed [DATA_W-1:0]  range_total;
        logic                      bad_request;
    } rsp_t;

    // sequencer status toward the top level
    typedef struct packed {
        logic ready;
        logic done;
    } seq_stat_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_U_DIFF,
        S_U_RD,
        S_U_WR,
        S_Q_LO,
        S_Q_LO_ACC,
        S_Q_HI,
        S_Q_HI_ACC,
        S_DONE
    } seq_state_t;

endpackage

[hw/rtl/range_sum_segment_tree_core.sv]
// ----------------------------------------------------------------------------
// range_sum_segment_tree_core
// Segment tree of wrapping 32-bit sums with point set and range-sum query.
// ----------------------------------------------------------------------------
// Request items enter on req_valid/req_ready, one response item per request
// leaves on rsp_valid/rsp_ready. The element count in use is written on the
// cfg channel (cfg_ready is always high), by the user only while the core is
// idle; the core does not enforce this. After reset the core runs a clearing
// pass over the node memory, one word a cycle, with req_ready low; then every
// element is zero. Requests are taken one at a time through the sequencer,
// which uses the shared adder and the single memory port:
//   set      : leaf-to-root update of the leaf and its ancestors
//   query    : bottom-up walk over the span, shorter for narrow spans
//   rejected : answered in the next cycle (bad_request set, range_total zero)
// The response sits in an output register; while it is not taken the core
// holds req_ready low, so a stalled receiver stalls the request side.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_core #(
    parameter int ELEMENTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rsst_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rsst_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [10:0]     cfg_data
);

    import rsst_pkg::*;

    localparam int LOG = $clog2(ELEMENTS);
    localparam int CW  = (LOG + 1 > COUNT_W) ? LOG + 1 : COUNT_W;

    logic [COUNT_W-1:0] count_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    seq_stat_t          seq_stat;
    logic [DATA_W-1:0]  seq_total;
    logic               req_fire, bad_req, seq_start;
    logic [CW-1:0]      count_w, eff_count, pos_w, left_w, right_w;

    // count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // request check against the count in use
    assign count_w   = CW'(count_reg);
    assign eff_count = (count_w > CW'(ELEMENTS)) ? CW'(ELEMENTS) : count_w;
    assign pos_w     = CW'(req.position);
    assign left_w    = CW'(req.range_left);
    assign right_w   = CW'(req.range_right);

    always_comb
    begin
        if (req.func == FUNC_SET)
        begin
            bad_req = (pos_w >= eff_count);
        end
        else
        begin
            bad_req = (left_w >= eff_count) || (right_w >= eff_count) || (left_w > right_w);
        end
    end

    assign req_ready = seq_stat.ready && !rsp_valid_reg;
    assign req_fire  = req_valid && req_ready;
    assign seq_start = req_fire && !bad_req;

    rsst_seq #(
        .ELEMENTS (ELEMENTS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .req   (req),
        .stat  (seq_stat),
        .total (seq_total)
    );

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_fire && bad_req)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.range_total = '0;
            rsp_next.bad_request = 1'b1;
        end
        else if (seq_stat.done)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.range_total = $signed(seq_total);
            rsp_next.bad_request = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_done_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.done |-> !rsp_valid_reg)
        else $error("sequencer finished while a response was still held");

    a_reject_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && bad_req) |=> (rsp_valid_reg && rsp_reg.bad_request))
        else $error("rejected request did not answer in one cycle");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.bad_request) |-> (rsp_reg.range_total == '0))
        else $error("rejected response carries a nonzero total");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_start |=> !seq_stat.ready)
        else $error("sequencer still ready after a start");

endmodule

[hw/rtl/rsst_node_ram.sv]
// ----------------------------------------------------------------------------
// rsst_node_ram
// Single-port node sum memory with registered read data.
// ----------------------------------------------------------------------------
module rsst_node_ram #(
    parameter int AW = 11,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];
    logic [DW-1:0] rdata_reg;

    // one address per cycle: optional write, and a registered read of the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rsst_seq.sv]
// ----------------------------------------------------------------------------
// rsst_seq
// Tree walk sequencer: clearing pass, leaf-to-root update and bottom-up
// range query, all through one shared 32-bit adder and one memory port.
// ----------------------------------------------------------------------------
module rsst_seq #(
    parameter int ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rsst_pkg::req_t     req,
    output rsst_pkg::seq_stat_t stat,
    output logic [31:0]        total
);

    import rsst_pkg::*;

    localparam int LOG = $clog2(ELEMENTS);
    localparam int AW  = LOG + 1;            // node numbers 1 .. 2*ELEMENTS-1
    localparam int PW  = LOG + 2;            // span bound may reach 2*ELEMENTS
    localparam int IW  = (LOG > INDEX_W) ? LOG : INDEX_W;

    seq_state_t state_reg, state_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] diff_reg, diff_next;
    logic [DATA_W-1:0] val_reg, val_next;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    // shared adder
    logic [DATA_W-1:0] add_a, add_b, add_sum;
    logic              add_sub;

    // element indices resized to the tree width
    logic [IW-1:0]     pos_w, left_w, right_w;
    logic [AW-1:0]     leaf_addr;
    logic [PW-1:0]     hi_dec;

    rsst_node_ram #(
        .AW (AW),
        .DW (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(DATA_W-1){1'b0}}, add_sub};

    assign pos_w     = IW'(req.position);
    assign left_w    = IW'(req.range_left);
    assign right_w   = IW'(req.range_right);
    assign leaf_addr = {1'b1, pos_w[LOG-1:0]};
    assign hi_dec    = hi_reg - PW'(1);

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diff_reg <= diff_next;
        val_reg  <= val_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_addr   = node_reg;
        mem_wdata  = add_sum;
        add_a      = acc_reg;
        add_b      = mem_rdata;
        add_sub    = 1'b0;
        stat.ready = 1'b0;
        stat.done  = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                node_next = node_reg + AW'(1);
                if (node_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                stat.ready = 1'b1;
                mem_addr   = leaf_addr;
                if (start)
                begin
                    acc_next = '0;
                    val_next = $unsigned(req.new_value);
                    if (req.func == FUNC_SET)
                    begin
                        node_next  = leaf_addr;
                        state_next = S_U_DIFF;
                    end
                    else
                    begin
                        lo_next    = PW'({1'b1, left_w[LOG-1:0]});
                        hi_next    = PW'({1'b1, right_w[LOG-1:0]}) + PW'(1);
                        state_next = S_Q_LO;
                    end
                end
            end

            // old leaf value is on the read port: leaf takes the new value
            S_U_DIFF:
            begin
                add_a      = val_reg;
                add_sub    = 1'b1;
                diff_next  = add_sum;
                mem_we     = 1'b1;
                mem_wdata  = val_reg;
                node_next  = node_reg >> 1;
                state_next = S_U_RD;
            end

            S_U_RD:
            begin
                state_next = S_U_WR;
            end

            // ancestor gets the difference added
            S_U_WR:
            begin
                add_a  = mem_rdata;
                add_b  = diff_reg;
                mem_we = 1'b1;
                if (node_reg == AW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    node_next  = node_reg >> 1;
                    state_next = S_U_RD;
                end
            end

            // left edge of the span
            S_Q_LO:
            begin
                mem_addr = lo_reg[AW-1:0];
                if (lo_reg >= hi_reg)
                begin
                    state_next = S_DONE;
                end
                else if (lo_reg[0])
                begin
                    state_next = S_Q_LO_ACC;
                end
                else
                begin
                    state_next = S_Q_HI;
                end
            end

            S_Q_LO_ACC:
            begin
                acc_next   = add_sum;
                lo_next    = lo_reg + PW'(1);
                state_next = S_Q_HI;
            end

            // right edge of the span
            S_Q_HI:
            begin
                mem_addr = hi_dec[AW-1:0];
                if (hi_reg[0])
                begin
                    hi_next    = hi_dec;
                    state_next = S_Q_HI_ACC;
                end
                else
                begin
                    lo_next    = lo_reg >> 1;
                    hi_next    = hi_reg >> 1;
                    state_next = S_Q_LO;
                end
            end

            S_Q_HI_ACC:
            begin
                acc_next   = add_sum;
                lo_next    = lo_reg >> 1;
                hi_next    = hi_reg >> 1;
                state_next = S_Q_LO;
            end

            S_DONE:
            begin
                stat.done  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign total = acc_reg;

endmodule
